// ----- src/csrast_pkg.sv -----
// Shared types, constants and command codes of the canvas shape rasterizer.
`timescale 1ns / 1ps

package csrast_pkg;

  localparam int DEF_ROWS = 16;
  localparam int DEF_COLS = 32;
  localparam int MAX_DUMP = 16;
  localparam int POS_W = 10;
  localparam int CALC_W = 2 * POS_W;

  typedef enum logic [2:0] {
    CMD_LINE   = 3'd0,
    CMD_RECT   = 3'd1,
    CMD_CIRCLE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FLUSH,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
    logic rd_draw;
  } ctrl_t;

  typedef struct packed {
    logic dump_ok;
  } status_t;

endpackage

// ----- src/csrast_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module csrast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/csrast_ctrl.sv -----
// Command controller: sequences row sweeps for draws and dumps.
`timescale 1ns / 1ps

module csrast_ctrl import csrast_pkg::*; #(
  parameter int CANVAS_ROWS = DEF_ROWS,
  localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1,
  localparam int DUMP_ROWS = (CANVAS_ROWS > MAX_DUMP) ? MAX_DUMP : CANVAS_ROWS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_stall_o,
  input  logic [2:0]       cmd_i,
  input  status_t          status_i,
  output ctrl_t            ctrl_o,
  output logic [ROW_W-1:0] rd_row_o
);

  state_e           state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;

  assign accept = cmd_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_LINE, CMD_RECT, CMD_CIRCLE: state_d = ST_DRAW;
            CMD_DUMP: state_d = ST_DUMP;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        if (row_q == ROW_W'(CANVAS_ROWS - 1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      ST_DUMP: begin
        if (status_i.dump_ok && (row_q == ROW_W'(DUMP_ROWS - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    cmd_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        cmd_stall_o = 1'b0;
        ctrl_o.load = accept;
        ctrl_o.clear = accept && (cmd_e'(cmd_i) == CMD_CLEAR);
      end
      ST_DRAW: begin
        ctrl_o.rd_en = 1'b1;
        ctrl_o.rd_draw = 1'b1;
      end
      ST_FLUSH: ctrl_o = '0;
      ST_DUMP: ctrl_o.rd_en = status_i.dump_ok;
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    row_d = row_q;
    if (state_q == ST_IDLE) begin
      row_d = '0;
    end else if (ctrl_o.rd_en) begin
      row_d = row_q + 1'b1;
    end
  end

  assign rd_row_o = row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- src/csrast_dpath.sv -----
// Datapath: canvas memory, per-row pixel masks and the dump output register.
`timescale 1ns / 1ps

module csrast_dpath import csrast_pkg::*; #(
  parameter int CANVAS_ROWS = DEF_ROWS,
  parameter int CANVAS_COLS = DEF_COLS,
  localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1,
  localparam int DUMP_ROWS = (CANVAS_ROWS > MAX_DUMP) ? MAX_DUMP : CANVAS_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic [ROW_W-1:0]   rd_row_i,
  output status_t            status_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [7:0]  row_pos_i,
  input  logic signed [7:0]  col_pos_i,
  input  logic signed [7:0]  span_width_i,
  input  logic signed [7:0]  span_height_i,
  input  logic [6:0]         radius_i,
  output logic               row_valid_o,
  input  logic               row_stall_i,
  output logic [3:0]         row_index_o,
  output logic [31:0]        row_bits_o,
  output logic               last_row_o
);

  localparam logic signed [POS_W-1:0]  ONE_P = 1;
  localparam logic signed [CALC_W-1:0] ONE_C = 1;

  cmd_e                     cmd_q;
  logic signed [7:0]        rp_q, cp_q, sw_q, sh_q;
  logic signed [15:0]       cc2_q;
  logic [13:0]              rsq_q;
  logic [CANVAS_ROWS-1:0]   valid_q, valid_d;
  logic                     rd_draw_q, rd_dump_q;
  logic [ROW_W-1:0]         rd_row_q;
  logic                     rd_vld_q;
  logic signed [CALC_W-1:0] di2_q;
  logic signed [POS_W-1:0]  di;
  logic signed [CALC_W-1:0] di2_d;
  logic [CANVAS_COLS-1:0]   rdata, old_word, mask, new_word;
  logic signed [POS_W-1:0]  iw, rp_w, cp_w, r1_w, c1_w, jw;
  logic signed [CALC_W-1:0] k_w, t_w;
  logic                     in_cols, in_rows, edge_row;
  logic [31:0]              bits32;
  logic                     out_valid_q, out_valid_d;
  logic [3:0]               out_index_q;
  logic [31:0]              out_bits_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(cmd_i);
      rp_q <= row_pos_i;
      cp_q <= col_pos_i;
      sw_q <= span_width_i;
      sh_q <= span_height_i;
      cc2_q <= col_pos_i * col_pos_i;
      rsq_q <= radius_i * radius_i;
    end
  end

  assign di = $signed(POS_W'(rd_row_i)) - POS_W'(rp_q);
  assign di2_d = di * di;

  always_ff @(posedge clk_i) begin
    rd_row_q <= rd_row_i;
    rd_vld_q <= valid_q[rd_row_i];
    di2_q <= di2_d;
  end

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = '0;
    end else if (rd_draw_q) begin
      valid_d[rd_row_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_draw_q <= 1'b0;
      rd_dump_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rd_draw_q <= ctrl_i.rd_en && ctrl_i.rd_draw;
      rd_dump_q <= ctrl_i.rd_en && !ctrl_i.rd_draw;
      out_valid_q <= out_valid_d;
    end
  end

  csrast_ram #(
    .WIDTH(CANVAS_COLS),
    .DEPTH(CANVAS_ROWS)
  ) u_canvas (
    .clk_i  (clk_i),
    .we_i   (rd_draw_q),
    .waddr_i(rd_row_q),
    .wdata_i(new_word),
    .raddr_i(rd_row_i),
    .rdata_o(rdata)
  );

  assign old_word = rd_vld_q ? rdata : '0;

  assign iw = $signed(POS_W'(rd_row_q));
  assign rp_w = POS_W'(rp_q);
  assign cp_w = POS_W'(cp_q);
  assign r1_w = rp_w + POS_W'(sh_q) - ONE_P;
  assign c1_w = cp_w + POS_W'(sw_q) - ONE_P;
  assign k_w = CALC_W'(cc2_q) + di2_q - $signed(CALC_W'(rsq_q));
  assign in_rows = (iw >= rp_w) && (iw <= r1_w);
  assign edge_row = (iw == rp_w) || (iw == r1_w);

  always_comb begin
    mask = '0;
    jw = '0;
    t_w = '0;
    in_cols = 1'b0;
    for (int j = 0; j < CANVAS_COLS; j++) begin
      jw = POS_W'(j);
      in_cols = (jw >= cp_w) && (jw <= c1_w);
      t_w = k_w + CALC_W'(j * j) - CALC_W'(2 * j) * CALC_W'(cp_q);
      case (cmd_q)
        CMD_LINE: mask[j] = (iw == rp_w) && in_cols;
        CMD_RECT: mask[j] = in_rows && in_cols && (edge_row || (jw == cp_w) || (jw == c1_w));
        CMD_CIRCLE: mask[j] = (t_w >= -ONE_C) && (t_w <= ONE_C);
        default: mask[j] = 1'b0;
      endcase
    end
  end

  assign new_word = old_word | mask;

  for (genvar b = 0; b < 32; b++) begin : g_bits
    if (b < CANVAS_COLS) begin : g_col
      assign bits32[b] = old_word[b];
    end else begin : g_pad
      assign bits32[b] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rd_dump_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !row_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_dump_q) begin
      out_index_q <= 4'(rd_row_q);
      out_bits_q <= bits32;
      out_last_q <= (rd_row_q == ROW_W'(DUMP_ROWS - 1));
    end
  end

  assign status_o.dump_ok = !rd_dump_q && (!out_valid_q || !row_stall_i);

  assign row_valid_o = out_valid_q;
  assign row_index_o = out_index_q;
  assign row_bits_o = out_bits_q;
  assign last_row_o = out_last_q;

endmodule

// ----- src/canvas_shape_rasterizer.sv -----
// Top level of the canvas shape rasterizer: controller plus datapath.
//
//   Channel   Direction  Handshake                  Word
//   command   in         cmd_valid_i / cmd_stall_o   cmd, row_pos, col_pos, span_width,
//                                                   span_height, radius
//   row       out        row_valid_o / row_stall_i   row_index, row_bits, last_row
//
// A draw command sweeps every canvas row with one read-modify-write per cycle and
// then passes through a flush state; clear and unused codes leave the controller idle.
// A dump reads rows one at a time: the next row read waits until the previous row
// has been loaded into the one-word output register.
// Reset and clear mark all rows blank at once through per-row valid bits.
// Output stalls pause a dump; the command side stalls while a sweep is in progress.
`timescale 1ns / 1ps

module canvas_shape_rasterizer import csrast_pkg::*; #(
  parameter int CANVAS_ROWS = DEF_ROWS,
  parameter int CANVAS_COLS = DEF_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_stall_o,
  input  logic [2:0]        cmd_i,
  input  logic signed [7:0] row_pos_i,
  input  logic signed [7:0] col_pos_i,
  input  logic signed [7:0] span_width_i,
  input  logic signed [7:0] span_height_i,
  input  logic [6:0]        radius_i,
  output logic              row_valid_o,
  input  logic              row_stall_i,
  output logic [3:0]        row_index_o,
  output logic [31:0]       row_bits_o,
  output logic              last_row_o
);

  localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

  ctrl_t            ctrl;
  status_t          status;
  logic [ROW_W-1:0] rd_row;

  csrast_ctrl #(
    .CANVAS_ROWS(CANVAS_ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid_i),
    .cmd_stall_o(cmd_stall_o),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .rd_row_o   (rd_row)
  );

  csrast_dpath #(
    .CANVAS_ROWS(CANVAS_ROWS),
    .CANVAS_COLS(CANVAS_COLS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .rd_row_i     (rd_row),
    .status_o     (status),
    .cmd_i        (cmd_i),
    .row_pos_i    (row_pos_i),
    .col_pos_i    (col_pos_i),
    .span_width_i (span_width_i),
    .span_height_i(span_height_i),
    .radius_i     (radius_i),
    .row_valid_o  (row_valid_o),
    .row_stall_i  (row_stall_i),
    .row_index_o  (row_index_o),
    .row_bits_o   (row_bits_o),
    .last_row_o   (last_row_o)
  );

endmodule

// ----- sim/canvas_shape_rasterizer_tb.sv -----
// Self-checking testbench for the canvas shape rasterizer with a canvas scoreboard.
`timescale 1ns / 1ps

module canvas_shape_rasterizer_tb;
  import csrast_pkg::*;

  localparam int ROWS = DEF_ROWS;
  localparam int COLS = DEF_COLS;
  localparam int RANDOM_ITEMS = 360;
  localparam int CALM_TAIL = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [2:0] CMD_LAST_CODE = 3'd7;

  class canvas_scoreboard;
    typedef struct {
      logic [3:0]  index;
      logic [31:0] bits;
      logic        last;
    } row_word_t;

    bit [COLS-1:0] pixels [ROWS];
    row_word_t     pending_rows [$];
    int            errors;

    function void set_pixel(int r, int c);
      if (r >= 0 && r < ROWS && c >= 0 && c < COLS) begin
        pixels[r][c] = 1'b1;
      end
    endfunction

    function void apply_command(logic [2:0] cmd, logic signed [7:0] rp,
                                logic signed [7:0] cp, logic signed [7:0] sw,
                                logic signed [7:0] sh, logic [6:0] rad);
      int r0;
      int c0;
      int w;
      int h;
      int rsq;
      int diff;
      row_word_t word;
      r0 = int'(rp);
      c0 = int'(cp);
      w = int'(sw);
      h = int'(sh);
      case (cmd)
        CMD_LINE: begin
          for (int j = c0; j < c0 + w; j++) set_pixel(r0, j);
        end
        CMD_RECT: begin
          if (w > 0 && h > 0) begin
            for (int i = r0; i <= r0 + h - 1; i++) begin
              for (int j = c0; j <= c0 + w - 1; j++) begin
                if (i == r0 || i == r0 + h - 1 || j == c0 || j == c0 + w - 1) begin
                  set_pixel(i, j);
                end
              end
            end
          end
        end
        CMD_CIRCLE: begin
          rsq = int'(rad) * int'(rad);
          for (int i = 0; i < ROWS; i++) begin
            for (int j = 0; j < COLS; j++) begin
              diff = (i - r0) * (i - r0) + (j - c0) * (j - c0) - rsq;
              if (diff >= -1 && diff <= 1) set_pixel(i, j);
            end
          end
        end
        CMD_CLEAR: begin
          foreach (pixels[i]) pixels[i] = '0;
        end
        CMD_DUMP: begin
          for (int i = 0; i < MAX_DUMP && i < ROWS; i++) begin
            word.index = 4'(i);
            word.bits = 32'(pixels[i]);
            word.last = (i == ((ROWS < MAX_DUMP) ? ROWS : MAX_DUMP) - 1);
            pending_rows.push_back(word);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_row(logic [3:0] index, logic [31:0] bits, logic last);
      row_word_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row word: expected none, got index %0d bits %h last %b",
                 $time, index, bits, last);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      if (index !== want.index) begin
        $display("%0t: row_index mismatch: expected %0d, got %0d", $time, want.index, index);
        errors++;
      end
      if (bits !== want.bits) begin
        $display("%0t: row_bits mismatch on row %0d: expected %h, got %h",
                 $time, want.index, want.bits, bits);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_row mismatch on row %0d: expected %b, got %b",
                 $time, want.index, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cmd_valid_i;
  logic              cmd_stall_o;
  logic [2:0]        cmd_i;
  logic signed [7:0] row_pos_i;
  logic signed [7:0] col_pos_i;
  logic signed [7:0] span_width_i;
  logic signed [7:0] span_height_i;
  logic [6:0]        radius_i;
  logic              row_valid_o;
  logic              row_stall_i;
  logic [3:0]        row_index_o;
  logic [31:0]       row_bits_o;
  logic              last_row_o;

  canvas_scoreboard sb;
  bit               idle_on;
  int               quiet_cycles;

  canvas_shape_rasterizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid_i),
    .cmd_stall_o   (cmd_stall_o),
    .cmd_i         (cmd_i),
    .row_pos_i     (row_pos_i),
    .col_pos_i     (col_pos_i),
    .span_width_i  (span_width_i),
    .span_height_i (span_height_i),
    .radius_i      (radius_i),
    .row_valid_o   (row_valid_o),
    .row_stall_i   (row_stall_i),
    .row_index_o   (row_index_o),
    .row_bits_o    (row_bits_o),
    .last_row_o    (last_row_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (cmd_valid_i && !cmd_stall_o) begin
        sb.apply_command(cmd_i, row_pos_i, col_pos_i, span_width_i, span_height_i,
                         radius_i);
      end
      if (row_valid_o && !row_stall_i) begin
        sb.check_row(row_index_o, row_bits_o, last_row_o);
      end
      if ((cmd_valid_i && !cmd_stall_o) || (row_valid_o && !row_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d row words outstanding",
                 $time, sb.pending_rows.size());
        $display("canvas_shape_rasterizer verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    row_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        row_stall_i = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        row_stall_i = 1'b1;
      end else begin
        row_stall_i = 1'b0;
      end
    end
  end

  task automatic issue_command(logic [2:0] cmd, logic signed [7:0] rp,
                               logic signed [7:0] cp, logic signed [7:0] sw,
                               logic signed [7:0] sh, logic [6:0] rad);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    cmd_valid_i = 1'b1;
    cmd_i = cmd;
    row_pos_i = rp;
    col_pos_i = cp;
    span_width_i = sw;
    span_height_i = sh;
    radius_i = rad;
    do @(posedge clk_i); while (cmd_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_rows_drained();
    cmd_valid_i = 1'b0;
    while (sb.pending_rows.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [7:0] pick_coord(int lo, int hi);
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  initial begin
    int pick;
    logic [2:0] cmd;
    sb = new;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cmd_valid_i = 1'b0;
    cmd_i = CMD_LINE;
    row_pos_i = '0;
    col_pos_i = '0;
    span_width_i = '0;
    span_height_i = '0;
    radius_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue_command(CMD_DUMP, 0, 0, 0, 0, 0);
    issue_command(CMD_LINE, 0, 0, 127, 0, 0);
    issue_command(CMD_LINE, 15, -5, 10, -128, 127);
    issue_command(CMD_LINE, 3, -128, 127, 0, 0);
    issue_command(CMD_LINE, 4, 5, 127, 0, 0);
    issue_command(CMD_LINE, 6, 6, 0, 0, 0);
    issue_command(CMD_LINE, 7, 6, -128, 0, 0);
    issue_command(CMD_LINE, 127, 0, 10, 0, 0);
    issue_command(CMD_RECT, 2, 3, 5, 4, 0);
    issue_command(CMD_RECT, 9, 20, 1, 1, 0);
    issue_command(CMD_RECT, 10, 10, 4, 0, 0);
    issue_command(CMD_RECT, 10, 10, -1, 3, 0);
    issue_command(CMD_RECT, -128, -128, 127, 127, 0);
    issue_command(CMD_DUMP, 0, 0, 0, 0, 0);
    issue_command(CMD_CLEAR, 0, 0, 0, 0, 0);
    issue_command(CMD_RECT, 0, 0, 32, 16, 0);
    issue_command(CMD_CIRCLE, 7, 15, 0, 0, 0);
    issue_command(CMD_CIRCLE, 8, 16, 0, 0, 6);
    issue_command(CMD_CIRCLE, 127, 127, 0, 0, 127);
    issue_command(CMD_CIRCLE, -128, -128, 0, 0, 127);
    issue_command(CMD_DUMP, 0, 0, 0, 0, 0);
    issue_command(3'(CMD_DUMP + 1), 1, 1, 5, 5, 3);
    issue_command(3'(CMD_DUMP + 2), -1, 127, -128, 127, 127);
    issue_command(CMD_LAST_CODE, 127, -128, 127, -128, 0);
    issue_command(CMD_DUMP, 0, 0, 0, 0, 0);
    wait_rows_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_TAIL) begin
        idle_on = 1'b0;
      end else if (n % 40 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (n % 90 == 45) wait_rows_drained();
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CMD_LINE;
      else if (pick < 45) cmd = CMD_RECT;
      else if (pick < 62) cmd = CMD_CIRCLE;
      else if (pick < 66) cmd = CMD_CLEAR;
      else if (pick < 90) cmd = CMD_DUMP;
      else cmd = 3'($urandom_range(CMD_DUMP + 1, CMD_LAST_CODE));
      issue_command(cmd, pick_coord(-4, ROWS + 3), pick_coord(-4, COLS + 3),
                    pick_coord(-4, COLS + 8), pick_coord(-3, ROWS + 4),
                    ($urandom_range(0, 4) == 0) ? 7'($urandom)
                                                 : 7'($urandom_range(0, 20)));
    end
    issue_command(CMD_DUMP, 0, 0, 0, 0, 0);

    wait_rows_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("canvas_shape_rasterizer verification clean");
    end else begin
      $display("canvas_shape_rasterizer verification failed");
    end
    $finish;
  end

endmodule
